@@ design/nrp_pkg.sv @@
// Shared types, constants and helper functions of the RMC position parser.
package nrp_pkg;

    // Sentence buffer and coordinate format
    localparam int MAX_SENTENCE    = 256;
    localparam int LEN_W           = $clog2(MAX_SENTENCE);
    localparam int FRACTION_DIGITS = 5;
    localparam int FRAC_SCALE      = 10 ** FRACTION_DIGITS;
    localparam int FRAC_W          = $clog2(FRAC_SCALE);
    localparam int INT_W           = 17;
    localparam int DEG_W           = 10;
    localparam int MIN_W           = 7;
    localparam int COORD_W         = 35;

    localparam logic [LEN_W-1:0] MAX_KEEP     = LEN_W'(MAX_SENTENCE - 1);
    localparam logic [INT_W-1:0] INT_LIMIT    = INT_W'(99999);
    localparam logic [2:0]       FRAC_CNT_MAX = 3'(FRACTION_DIGITS);

    // Fixed point scaling: degrees * 10^7
    localparam longint unsigned SCALE   = 64'd10_000_000;
    // minutes * 10^F scaled up so that one divide by 60 gives degrees * 10^7
    localparam longint unsigned MIN_NUM = 64'd10 ** (7 - FRACTION_DIGITS);
    localparam int M_W  = 30;
    localparam int Q_W  = 25;
    localparam int DEGS_W = 34;

    // Integer part / 100 by reciprocal (underestimates by at most one)
    localparam int              DIV100_SHIFT = 19;
    localparam longint unsigned DIV100_RECIP = 64'd5242;
    // x / 60 by reciprocal, exact for x below 2^30
    localparam int              DIV60_SHIFT  = 36;
    localparam longint unsigned DIV60_RECIP  = ((64'd1 << DIV60_SHIFT) + 64'd59) / 64'd60;

    // Conversion pipeline depth inside nrp_coord_convert
    localparam int CONV_STAGES = 6;

    // ASCII codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_N      = 8'h4E;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_W      = 8'h57;

    // Sentence status codes
    typedef enum logic [2:0] {
        ST_NOT_RMC    = 3'd0,
        ST_FEW_FIELDS = 3'd1,
        ST_NO_FIX     = 3'd2,
        ST_SHORT      = 3'd3,
        ST_FIX        = 3'd4
    } status_t;

    // Running state of one coordinate field
    // digits: bit4 number ended, bit3 past the point, bits2:0 fraction digits kept
    typedef struct packed {
        logic [INT_W-1:0]  int_part;
        logic [FRAC_W-1:0] frac;
        logic [4:0]        digits;
        logic [LEN_W-1:0]  len;
        logic              neg;
    } coord_state_t;

    // Coordinate handed to the converter
    typedef struct packed {
        logic [INT_W-1:0]  ip;
        logic [FRAC_W-1:0] fp;
        logic [2:0]        cnt;
        logic              neg;
    } coord_in_t;

    // One finished sentence
    typedef struct packed {
        status_t   status;
        coord_in_t lat;
        coord_in_t lon;
    } snap_t;

    // Powers of ten for fraction alignment
    function automatic logic [FRAC_W-1:0] pow10(input logic [2:0] idx);
        logic [23:0] p;
        unique case (idx)
            3'd0:    p = 24'd1;
            3'd1:    p = 24'd10;
            3'd2:    p = 24'd100;
            3'd3:    p = 24'd1000;
            3'd4:    p = 24'd10000;
            3'd5:    p = 24'd100000;
            3'd6:    p = 24'd1000000;
            default: p = 24'd10000000;
        endcase
        return FRAC_W'(p);
    endfunction

    // Header character at a position, GP or GN talker
    function automatic logic [7:0] hdr_char(input logic [2:0] idx, input logic gn);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = CH_DOLLAR;
            3'd1:    ch = CH_G;
            3'd2:    ch = gn ? CH_N : CH_P;
            3'd3:    ch = CH_R;
            3'd4:    ch = CH_M;
            default: ch = CH_C;
        endcase
        return ch;
    endfunction

    // One character of a DDDMM.MMMMM field
    function automatic coord_state_t coord_step(input coord_state_t s, input logic [7:0] c);
        coord_state_t r;
        logic [3:0]   d;
        logic [20:0]  v;
        logic [23:0]  f;
        r = s;
        d = c[3:0];
        v = 21'(s.int_part) * 21'd10 + 21'(d);
        f = 24'(s.frac) * 24'd10 + 24'(d);
        r.len = s.len + LEN_W'(1);
        if (!s.digits[4]) begin
            if (c >= CH_0 && c <= CH_9) begin
                if (s.digits[3]) begin
                    if (s.digits[2:0] < FRAC_CNT_MAX) begin
                        r.frac   = FRAC_W'(f);
                        r.digits = {2'b01, s.digits[2:0] + 3'd1};
                    end
                end else begin
                    r.int_part = (v > 21'(INT_LIMIT)) ? INT_LIMIT : v[INT_W-1:0];
                end
            end else if (c == CH_DOT && !s.digits[3]) begin
                r.digits = 5'b01000;
            end else begin
                r.digits[4] = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

@@ design/nrp_if.sv @@
// Handshake channel interfaces: received byte stream and sentence results.
interface nrp_byte_if ();
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nrp_result_if import nrp_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [2:0]                sentence_status;
    logic signed [COORD_W-1:0] latitude;
    logic signed [COORD_W-1:0] longitude;
    logic                      fix_valid;

    modport source (output valid, output sentence_status, output latitude,
                    output longitude, output fix_valid, input ready);
    modport sink   (input valid, input sentence_status, input latitude,
                    input longitude, input fix_valid, output ready);
endinterface

@@ design/nrp_sentence_parser.sv @@
// Per-byte sentence parser: header match, field split, coordinate digit capture.
module nrp_sentence_parser import nrp_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       accept,
    input  logic [7:0] rx_byte,
    output logic       snap_valid,
    output snap_t      snap
);

    localparam logic [3:0] FIELD_STATUS   = 4'd2;
    localparam logic [3:0] FIELD_LAT      = 4'd3;
    localparam logic [3:0] FIELD_LAT_HEMI = 4'd4;
    localparam logic [3:0] FIELD_LON      = 4'd5;
    localparam logic [3:0] FIELD_LON_HEMI = 4'd6;
    localparam logic [3:0] FIELD_MIN      = 4'd6;
    localparam logic [3:0] FIELD_SAT      = 4'd12;
    localparam logic [LEN_W-1:0] HDR_LEN  = LEN_W'(6);
    localparam logic [LEN_W-1:0] MIN_COORD_LEN = LEN_W'(4);

    typedef struct packed {
        logic [LEN_W-1:0] length;
        logic [1:0]       hdr;
        logic [3:0]       field;
        logic             ck_seen;
        logic             empty;
        logic [7:0]       status_ch;
        coord_state_t     lat;
        coord_state_t     lon;
    } parse_state_t;

    localparam parse_state_t CLEAR_STATE = '{
        length: '0, hdr: 2'b11, field: '0, ck_seen: 1'b0, empty: 1'b1,
        status_ch: '0, lat: '0, lon: '0
    };

    parse_state_t state_reg, state_next;
    parse_state_t base, upd;
    status_t      status;
    logic         newline;
    logic         snap_valid_reg;
    snap_t        snap_reg;

    assign newline = (rx_byte == CH_NL);

    // Byte update of the sentence state
    always_comb
    begin
        base = (rx_byte == CH_DOLLAR) ? CLEAR_STATE : state_reg;
        upd  = base;
        if (base.length < MAX_KEEP)
        begin
            if (base.length < HDR_LEN)
            begin
                if (rx_byte != hdr_char(base.length[2:0], 1'b0)) upd.hdr[0] = 1'b0;
                if (rx_byte != hdr_char(base.length[2:0], 1'b1)) upd.hdr[1] = 1'b0;
            end
            if (!base.ck_seen)
            begin
                if (rx_byte == CH_NUL || rx_byte == CH_STAR)
                begin
                    upd.ck_seen = 1'b1;
                end
                else if (rx_byte == CH_COMMA && base.field < FIELD_SAT)
                begin
                    upd.field = base.field + 4'd1;
                    upd.empty = 1'b1;
                end
                else
                begin
                    unique case (base.field)
                        FIELD_STATUS:   if (base.empty) upd.status_ch = rx_byte;
                        FIELD_LAT:      upd.lat = coord_step(base.lat, rx_byte);
                        FIELD_LAT_HEMI: if (base.empty) upd.lat.neg = (rx_byte == CH_S);
                        FIELD_LON:      upd.lon = coord_step(base.lon, rx_byte);
                        FIELD_LON_HEMI: if (base.empty) upd.lon.neg = (rx_byte == CH_W);
                        default:        ;
                    endcase
                    upd.empty = 1'b0;
                end
            end
            upd.length = base.length + LEN_W'(1);
        end
        state_next = newline ? CLEAR_STATE : upd;
    end

    // Sentence verdict at the newline
    always_comb
    begin
        priority if (upd.length < HDR_LEN || upd.hdr == 2'b00)
            status = ST_NOT_RMC;
        else if (upd.field < FIELD_MIN)
            status = ST_FEW_FIELDS;
        else if (upd.status_ch != CH_A)
            status = ST_NO_FIX;
        else if (upd.lat.len < MIN_COORD_LEN || upd.lon.len < MIN_COORD_LEN)
            status = ST_SHORT;
        else
            status = ST_FIX;
    end

    // Sentence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= CLEAR_STATE;
            snap_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            if (accept) state_reg <= state_next;
            snap_valid_reg <= accept && newline;
        end
    end

    // Snapshot of the finished sentence
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            snap_reg.status  <= status;
            snap_reg.lat.ip  <= upd.lat.int_part;
            snap_reg.lat.fp  <= upd.lat.frac;
            snap_reg.lat.cnt <= upd.lat.digits[2:0];
            snap_reg.lat.neg <= upd.lat.neg;
            snap_reg.lon.ip  <= upd.lon.int_part;
            snap_reg.lon.fp  <= upd.lon.frac;
            snap_reg.lon.cnt <= upd.lon.digits[2:0];
            snap_reg.lon.neg <= upd.lon.neg;
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

endmodule

@@ design/nrp_coord_convert.sv @@
// Pipelined DDDMM.MMMMM to signed degrees * 10^7 conversion, one coordinate.
module nrp_coord_convert import nrp_pkg::*; (
    input  logic                      clk,
    input  logic                      en,
    input  coord_in_t                 coord,
    output logic signed [COORD_W-1:0] value
);

    logic [INT_W-1:0]   ip1_reg;
    logic [DEG_W-1:0]   qe1_reg;
    logic [FRAC_W-1:0]  fs1_reg, fs2_reg;
    logic               neg1_reg, neg2_reg, neg3_reg, neg4_reg, neg5_reg;
    logic [DEG_W-1:0]   deg2_reg;
    logic [MIN_W-1:0]   min2_reg;
    logic [M_W-1:0]     m3_reg, x4_reg;
    logic [DEGS_W-1:0]  degs3_reg, degs4_reg, degs5_reg;
    logic [Q_W-1:0]     q5_reg;
    logic [COORD_W-1:0] value_reg;

    logic [INT_W+13:0]     div_prod;
    logic [2*FRAC_W-1:0]   frac_prod;
    logic [INT_W:0]        rem_w;
    logic [2*M_W:0]        q_prod;
    logic [COORD_W-1:0]    sum;

    always_comb
    begin
        div_prod  = (INT_W+14)'(coord.ip) * (INT_W+14)'(DIV100_RECIP);
        frac_prod = (2*FRAC_W)'(coord.fp) * (2*FRAC_W)'(pow10(FRAC_CNT_MAX - coord.cnt));
        rem_w     = (INT_W+1)'(ip1_reg) - (INT_W+1)'(qe1_reg) * (INT_W+1)'(100);
        q_prod    = (2*M_W+1)'(x4_reg) * (2*M_W+1)'(DIV60_RECIP);
        sum       = COORD_W'(degs5_reg) + COORD_W'(q5_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Degree estimate and fraction aligned to a fixed digit count
            ip1_reg  <= coord.ip;
            qe1_reg  <= DEG_W'(div_prod >> DIV100_SHIFT);
            fs1_reg  <= FRAC_W'(frac_prod);
            neg1_reg <= coord.neg;
            // Correct the degree estimate, split off whole minutes
            if (rem_w >= (INT_W+1)'(100))
            begin
                deg2_reg <= qe1_reg + DEG_W'(1);
                min2_reg <= MIN_W'(rem_w - (INT_W+1)'(100));
            end
            else
            begin
                deg2_reg <= qe1_reg;
                min2_reg <= MIN_W'(rem_w);
            end
            fs2_reg  <= fs1_reg;
            neg2_reg <= neg1_reg;
            // Minutes in fraction units, degrees scaled
            m3_reg    <= M_W'(min2_reg) * M_W'(FRAC_SCALE) + M_W'(fs2_reg);
            degs3_reg <= DEGS_W'(deg2_reg) * DEGS_W'(SCALE);
            neg3_reg  <= neg2_reg;
            // Bring minutes to 10^7 / 60 units
            x4_reg    <= m3_reg * M_W'(MIN_NUM);
            degs4_reg <= degs3_reg;
            neg4_reg  <= neg3_reg;
            // Divide by 60
            q5_reg    <= Q_W'(q_prod >> DIV60_SHIFT);
            degs5_reg <= degs4_reg;
            neg5_reg  <= neg4_reg;
            // Sum and apply hemisphere sign
            value_reg <= neg5_reg ? (COORD_W'(0) - sum) : sum;
        end
    end

    assign value = value_reg;

endmodule

@@ design/nmea_rmc_position_parser_top.sv @@
// Top level of the NMEA RMC position parser: byte input, result output.
// Takes one received byte per cycle while not stalled; the input may have gaps.
// Every newline byte yields one result transaction carrying the sentence status,
// the stored latitude and longitude (signed degrees * 10^7) and the fix flag;
// other bytes yield nothing. A result passes through the parser snapshot
// register, the six-stage coordinate conversion pipeline and the output
// register. The pipeline stalls, and the byte input with it, only when a
// finished result reaches the last conversion stage while the output register
// still holds one that is not being taken, so bytes keep flowing while a single
// result waits.
module nmea_rmc_position_parser_top import nrp_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    nrp_byte_if.sink            rx,
    nrp_result_if.source        report
);

    logic                      en;
    logic                      accept;
    logic                      out_load;
    logic                      snap_valid;
    snap_t                     snap;
    logic signed [COORD_W-1:0] lat_value, lon_value;

    logic                      v_pipe_reg  [CONV_STAGES];
    status_t                   st_pipe_reg [CONV_STAGES];

    logic signed [COORD_W-1:0] stored_lat_reg, stored_lat_next;
    logic signed [COORD_W-1:0] stored_lon_reg, stored_lon_next;
    logic                      fix_reg, fix_next;

    logic                      out_valid_reg;
    status_t                   out_status_reg;
    logic signed [COORD_W-1:0] out_lat_reg, out_lon_reg;
    logic                      out_fix_reg;

    // Pipeline advance: hold only when a finished result cannot move on
    assign en       = !v_pipe_reg[CONV_STAGES-1] || !out_valid_reg || report.ready;
    assign out_load = en && v_pipe_reg[CONV_STAGES-1];
    assign accept   = rx.valid && en;
    assign rx.ready = en;

    nrp_sentence_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .accept     (accept),
        .rx_byte    (rx.rx_byte),
        .snap_valid (snap_valid),
        .snap       (snap)
    );

    nrp_coord_convert u_lat_conv (
        .clk   (clk),
        .en    (en),
        .coord (snap.lat),
        .value (lat_value)
    );

    nrp_coord_convert u_lon_conv (
        .clk   (clk),
        .en    (en),
        .coord (snap.lon),
        .value (lon_value)
    );

    // Status travels alongside the conversion
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CONV_STAGES; i++) v_pipe_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            v_pipe_reg[0] <= snap_valid;
            for (int i = 1; i < CONV_STAGES; i++) v_pipe_reg[i] <= v_pipe_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_pipe_reg[0] <= snap.status;
            for (int i = 1; i < CONV_STAGES; i++) st_pipe_reg[i] <= st_pipe_reg[i-1];
        end
    end

    // Stored position and fix flag update
    always_comb
    begin
        stored_lat_next = stored_lat_reg;
        stored_lon_next = stored_lon_reg;
        fix_next        = fix_reg;
        if (v_pipe_reg[CONV_STAGES-1])
        begin
            if (st_pipe_reg[CONV_STAGES-1] == ST_FIX)
            begin
                stored_lat_next = lat_value;
                stored_lon_next = lon_value;
                fix_next        = 1'b1;
            end
            else if (st_pipe_reg[CONV_STAGES-1] == ST_NO_FIX)
            begin
                fix_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_lat_reg <= '0;
            stored_lon_reg <= '0;
            fix_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                stored_lat_reg <= stored_lat_next;
                stored_lon_reg <= stored_lon_next;
                fix_reg        <= fix_next;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (report.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= st_pipe_reg[CONV_STAGES-1];
            out_lat_reg    <= stored_lat_next;
            out_lon_reg    <= stored_lon_next;
            out_fix_reg    <= fix_next;
        end
    end

    assign report.valid           = out_valid_reg;
    assign report.sentence_status = out_status_reg;
    assign report.latitude        = out_lat_reg;
    assign report.longitude       = out_lon_reg;
    assign report.fix_valid       = out_fix_reg;

endmodule
